// ===== rtl/llr_statistics_monitor_top_defines.svh =====
// assertion macros for the llr statistics monitor
`ifndef LLR_STATISTICS_MONITOR_TOP_DEFINES_SVH
`define LLR_STATISTICS_MONITOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define LSM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("llr statistics monitor check failed");

// next-cycle implication, sampled on clock, off during reset
`define LSM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("llr statistics monitor check failed");

`endif

// ===== rtl/lsm_pkg.sv =====
// shared constants, codes and bin mapping for the llr statistics monitor
package lsm_pkg;

   localparam int POINTS_DEF       = 4;
   localparam int COUNTER_BITS_DEF = 48;
   localparam int BINS             = 12;
   localparam int BIN_BITS         = 4;
   localparam int OUT_CNT_BITS     = 48;
   localparam int MAG_BITS         = 32;
   localparam int SUM_BITS         = 64;
   localparam int EDGES            = 10;

   localparam logic [MAG_BITS-1:0] NO_CLAMP = 32'h7FFF_FFFF;

   // upper edges of bins 1 to 10, inclusive
   localparam logic [MAG_BITS-1:0] BIN_EDGES [EDGES] = '{
      32'd10, 32'd50, 32'd100, 32'd500, 32'd1000,
      32'd5000, 32'd10000, 32'd50000, 32'd100000, 32'd500000
   };

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_TRUTH  = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   function automatic logic [BIN_BITS-1:0] bin_of(input logic [MAG_BITS-1:0] mag);
      logic [BIN_BITS-1:0] b;
      b = BIN_BITS'(BINS - 1);
      for (int i = EDGES - 1; i >= 0; i--) begin
         if (mag <= BIN_EDGES[i]) b = BIN_BITS'(i + 1);
      end
      if (mag == '0) b = '0;
      return b;
   endfunction

endpackage

// ===== rtl/llr_statistics_monitor_top.sv =====
// llr statistics monitor: per-point counters, sums and histogram in two memories
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_ready  kind, point, llr_value, clamp_level,
//                                          truth_bit, bin_select
//   rsp_      out   rsp_valid / rsp_ready  counts, magnitudes, sums, bin index and count
//
// one transaction per cycle unless the output holds; a result reaches the output register
// after memory read with magnitude and square, then update and write back
// the write of one transaction is forwarded to the next one, so the same point can repeat
// every cycle; a clear drops all entry valid bits at once, no clearing pass
// reset empties the pipeline and drops all valid bits, so every entry reads as zero
// when the output register is full and rsp_ready is low, the whole pipeline holds
`include "llr_statistics_monitor_top_defines.svh"

module llr_statistics_monitor_top #(
   parameter int POINTS       = lsm_pkg::POINTS_DEF,
   parameter int COUNTER_BITS = lsm_pkg::COUNTER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_point,
   input  logic signed [31:0] req_llr_value,
   input  logic signed [31:0] req_clamp_level,
   input  logic        req_truth_bit,
   input  logic [3:0]  req_bin_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_sample_count,
   output logic [47:0] rsp_positive_count,
   output logic [47:0] rsp_negative_count,
   output logic [47:0] rsp_zero_value_count,
   output logic [31:0] rsp_largest_magnitude,
   output logic [31:0] rsp_smallest_nonzero_magnitude,
   output logic [47:0] rsp_clamp_hit_count,
   output logic [47:0] rsp_sign_match_count,
   output logic [63:0] rsp_magnitude_sum,
   output logic [63:0] rsp_square_sum,
   output logic [3:0]  rsp_bin_index,
   output logic [47:0] rsp_bin_count
);

   localparam int CB  = COUNTER_BITS;
   localparam int OCB = lsm_pkg::OUT_CNT_BITS;
   localparam int MB  = lsm_pkg::MAG_BITS;
   localparam int SB  = lsm_pkg::SUM_BITS;
   localparam int BB  = lsm_pkg::BIN_BITS;
   localparam int PW  = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int HD  = POINTS * lsm_pkg::BINS;
   localparam int HA  = $clog2(HD);

   typedef struct packed {
      logic [CB-1:0] samples;
      logic [CB-1:0] positives;
      logic [CB-1:0] negatives;
      logic [CB-1:0] zeros;
      logic [CB-1:0] clip_hits;
      logic [CB-1:0] sign_matches;
      logic [MB-1:0] max_mag;
      logic [MB-1:0] min_mag;
      logic [SB-1:0] mag_sum;
      logic [SB-1:0] square_sum;
   } point_stats_type;

   function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] c, input logic en);
      return (en && c != '1) ? c + CB'(1) : c;
   endfunction

   function automatic logic [SB-1:0] add_sat(input logic [SB-1:0] s, input logic [SB-1:0] v);
      logic [SB:0] t;
      t = {1'b0, s} + {1'b0, v};
      return t[SB] ? '1 : t[SB-1:0];
   endfunction

   // memories and entry valid bits
   point_stats_type pt_mem [POINTS];
   logic [CB-1:0]   hist_mem [HD];
   logic [POINTS-1:0] pt_vld_ff;
   logic [HD-1:0]     hist_vld_ff;

   logic advance;

   // stage 1: captured transaction
   logic              s1_vld_ff;
   lsm_pkg::kind_type s1_kind_ff;
   logic [1:0]        s1_point_ff;
   logic [MB-1:0]     s1_llr_ff;
   logic [MB-1:0]     s1_clamp_ff;
   logic              s1_truth_ff;
   logic [3:0]        s1_sel_ff;

   logic          s1_pt_ok;
   logic          s1_rec;
   logic [PW-1:0] s1_pt_idx;
   logic [MB-1:0] s1_mag;
   logic [MB-1:0] s1_cmag;
   logic [SB-1:0] s1_sq;
   logic [BB-1:0] s1_sel_clip;
   logic [BB-1:0] s1_bin;
   logic [HA-1:0] s1_haddr;
   logic          s1_zero;
   logic          s1_clamp_hit;
   logic          s1_match;

   // stage 2: read data and prepared operands
   logic              s2_vld_ff;
   lsm_pkg::kind_type s2_kind_ff;
   logic              s2_pt_ok_ff;
   logic [PW-1:0]     s2_pt_idx_ff;
   logic [MB-1:0]     s2_mag_ff;
   logic [SB-1:0]     s2_sq_ff;
   logic [BB-1:0]     s2_bin_ff;
   logic [HA-1:0]     s2_haddr_ff;
   logic              s2_zero_ff;
   logic              s2_neg_ff;
   logic              s2_clamp_hit_ff;
   logic              s2_match_ff;
   point_stats_type   s2_pt_rd_ff;
   logic              s2_pt_rv_ff;
   logic [CB-1:0]     s2_h_rd_ff;
   logic              s2_h_rv_ff;

   // last write back, for forwarding
   logic            wb_pt_en_ff;
   logic [PW-1:0]   wb_pt_idx_ff;
   point_stats_type wb_pt_data_ff;
   logic            wb_h_en_ff;
   logic [HA-1:0]   wb_h_addr_ff;
   logic [CB-1:0]   wb_h_data_ff;
   logic            wb_clear_ff;

   logic            s2_rec;
   logic            s2_clear;
   logic            s2_wr;
   point_stats_type pt_cur;
   point_stats_type pt_new;
   logic [CB-1:0]   h_cur;
   logic [CB-1:0]   h_new;

   // output register
   logic            rsp_valid_ff;
   point_stats_type rsp_word_ff;
   point_stats_type rsp_word_in;
   logic [BB-1:0]   rsp_bin_ff;
   logic [CB-1:0]   rsp_hcnt_ff;
   logic [CB-1:0]   rsp_hcnt_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // stage 1 logic
   always_comb begin
      s1_pt_ok    = {3'b000, s1_point_ff} < 5'(POINTS);
      s1_rec      = (s1_kind_ff == lsm_pkg::KIND_RECORD) || (s1_kind_ff == lsm_pkg::KIND_TRUTH);
      s1_pt_idx   = s1_pt_ok ? PW'(s1_point_ff) : '0;
      s1_mag      = s1_llr_ff[MB-1] ? (~s1_llr_ff + MB'(1)) : s1_llr_ff;
      s1_cmag     = s1_clamp_ff[MB-1] ? (~s1_clamp_ff + MB'(1)) : s1_clamp_ff;
      s1_sq       = SB'(s1_mag) * SB'(s1_mag);
      s1_sel_clip = (s1_sel_ff > BB'(lsm_pkg::BINS - 1)) ? BB'(lsm_pkg::BINS - 1) : s1_sel_ff;
      s1_bin      = s1_rec ? lsm_pkg::bin_of(s1_mag) : s1_sel_clip;
      s1_haddr    = s1_pt_ok ? (HA'(s1_pt_idx) * HA'(lsm_pkg::BINS) + HA'(s1_bin)) : '0;
      s1_zero     = (s1_llr_ff == '0);
      // clamp level of all ones below the sign disables the check
      s1_clamp_hit = (s1_clamp_ff != lsm_pkg::NO_CLAMP) && (s1_cmag != '0)
                     && (s1_mag >= s1_cmag);
      s1_match    = (s1_kind_ff == lsm_pkg::KIND_TRUTH) && !s1_zero
                    && (s1_llr_ff[MB-1] == s1_truth_ff);
   end

   // stage 2 logic: merge forwarded data, update, write back
   always_comb begin
      s2_rec   = (s2_kind_ff == lsm_pkg::KIND_RECORD) || (s2_kind_ff == lsm_pkg::KIND_TRUTH);
      s2_clear = (s2_kind_ff == lsm_pkg::KIND_CLEAR);
      s2_wr    = advance && s2_vld_ff && s2_rec && s2_pt_ok_ff;

      priority if (wb_clear_ff) begin
         pt_cur = '0;
      end else if (wb_pt_en_ff && wb_pt_idx_ff == s2_pt_idx_ff) begin
         pt_cur = wb_pt_data_ff;
      end else if (s2_pt_rv_ff) begin
         pt_cur = s2_pt_rd_ff;
      end else begin
         pt_cur = '0;
      end

      priority if (wb_clear_ff) begin
         h_cur = '0;
      end else if (wb_h_en_ff && wb_h_addr_ff == s2_haddr_ff) begin
         h_cur = wb_h_data_ff;
      end else if (s2_h_rv_ff) begin
         h_cur = s2_h_rd_ff;
      end else begin
         h_cur = '0;
      end

      pt_new              = pt_cur;
      pt_new.samples      = inc_sat(pt_cur.samples, 1'b1);
      pt_new.zeros        = inc_sat(pt_cur.zeros, s2_zero_ff);
      pt_new.negatives    = inc_sat(pt_cur.negatives, !s2_zero_ff && s2_neg_ff);
      pt_new.positives    = inc_sat(pt_cur.positives, !s2_zero_ff && !s2_neg_ff);
      pt_new.clip_hits    = inc_sat(pt_cur.clip_hits, s2_clamp_hit_ff);
      pt_new.sign_matches = inc_sat(pt_cur.sign_matches, s2_match_ff);
      pt_new.mag_sum      = add_sat(pt_cur.mag_sum, SB'(s2_mag_ff));
      pt_new.square_sum   = add_sat(pt_cur.square_sum, s2_sq_ff);
      if (s2_mag_ff > pt_cur.max_mag) pt_new.max_mag = s2_mag_ff;
      // zero minimum means no nonzero sample yet
      if (s2_mag_ff != '0 && (pt_cur.min_mag == '0 || s2_mag_ff < pt_cur.min_mag))
         pt_new.min_mag = s2_mag_ff;
      h_new = inc_sat(h_cur, 1'b1);

      if (s2_clear || !s2_pt_ok_ff) begin
         rsp_word_in = '0;
         rsp_hcnt_in = '0;
      end else if (s2_rec) begin
         rsp_word_in = pt_new;
         rsp_hcnt_in = h_new;
      end else begin
         rsp_word_in = pt_cur;
         rsp_hcnt_in = h_cur;
      end
   end

   // memories: registered read, write back from stage 2
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pt_rd_ff <= pt_mem[s1_pt_idx];
         s2_h_rd_ff  <= hist_mem[s1_haddr];
      end
      if (s2_wr) begin
         pt_mem[s2_pt_idx_ff]  <= pt_new;
         hist_mem[s2_haddr_ff] <= h_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_vld_ff   <= '0;
         hist_vld_ff <= '0;
      end else if (advance && s2_vld_ff && s2_clear) begin
         pt_vld_ff   <= '0;
         hist_vld_ff <= '0;
      end else if (s2_wr) begin
         pt_vld_ff[s2_pt_idx_ff]  <= 1'b1;
         hist_vld_ff[s2_haddr_ff] <= 1'b1;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_pt_en_ff  <= 1'b0;
         wb_h_en_ff   <= 1'b0;
         wb_clear_ff  <= 1'b0;
      end else if (advance) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         rsp_valid_ff <= s2_vld_ff;
         wb_pt_en_ff  <= s2_wr;
         wb_h_en_ff   <= s2_wr;
         wb_clear_ff  <= s2_vld_ff && s2_clear;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= lsm_pkg::kind_type'(req_kind);
         s1_point_ff <= req_point;
         s1_llr_ff   <= req_llr_value;
         s1_clamp_ff <= req_clamp_level;
         s1_truth_ff <= req_truth_bit;
         s1_sel_ff   <= req_bin_select;

         s2_kind_ff      <= s1_kind_ff;
         s2_pt_ok_ff     <= s1_pt_ok;
         s2_pt_idx_ff    <= s1_pt_idx;
         s2_mag_ff       <= s1_mag;
         s2_sq_ff        <= s1_sq;
         s2_bin_ff       <= s1_bin;
         s2_haddr_ff     <= s1_haddr;
         s2_zero_ff      <= s1_zero;
         s2_neg_ff       <= s1_llr_ff[MB-1];
         s2_clamp_hit_ff <= s1_clamp_hit;
         s2_match_ff     <= s1_match;
         s2_pt_rv_ff     <= pt_vld_ff[s1_pt_idx];
         s2_h_rv_ff      <= hist_vld_ff[s1_haddr];

         wb_pt_idx_ff  <= s2_pt_idx_ff;
         wb_pt_data_ff <= pt_new;
         wb_h_addr_ff  <= s2_haddr_ff;
         wb_h_data_ff  <= h_new;

         rsp_word_ff <= rsp_word_in;
         rsp_bin_ff  <= s2_bin_ff;
         rsp_hcnt_ff <= rsp_hcnt_in;
      end
   end

   assign rsp_valid                      = rsp_valid_ff;
   assign rsp_sample_count               = OCB'(rsp_word_ff.samples);
   assign rsp_positive_count             = OCB'(rsp_word_ff.positives);
   assign rsp_negative_count             = OCB'(rsp_word_ff.negatives);
   assign rsp_zero_value_count           = OCB'(rsp_word_ff.zeros);
   assign rsp_largest_magnitude          = rsp_word_ff.max_mag;
   assign rsp_smallest_nonzero_magnitude = rsp_word_ff.min_mag;
   assign rsp_clamp_hit_count            = OCB'(rsp_word_ff.clip_hits);
   assign rsp_sign_match_count           = OCB'(rsp_word_ff.sign_matches);
   assign rsp_magnitude_sum              = rsp_word_ff.mag_sum;
   assign rsp_square_sum                 = rsp_word_ff.square_sum;
   assign rsp_bin_index                  = rsp_bin_ff;
   assign rsp_bin_count                  = OCB'(rsp_hcnt_ff);

   `LSM_ASSERT_NXT(a_clear_drops_valid, advance && s2_vld_ff && s2_clear, pt_vld_ff == '0 && hist_vld_ff == '0)
   `LSM_ASSERT_IMP(a_min_not_above_max, s2_wr, pt_new.min_mag == '0 || pt_new.min_mag <= pt_new.max_mag)
   `LSM_ASSERT_IMP(a_signs_within_samples, s2_wr, pt_new.positives <= pt_new.samples && pt_new.negatives <= pt_new.samples)
   `LSM_ASSERT_NXT(a_write_forwarded, s2_wr, wb_pt_en_ff && wb_h_en_ff && !wb_clear_ff)

endmodule
